// ===== hw/rtl/psu_pkg.sv =====
// Shared types, register indexes and conversion functions of the PCM sample unpacker.
package psu_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_SAMPLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BINARY_8BIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_SAMPLES      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT      = 3'd4;

    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_24 = 2'd2;
    localparam logic [1:0] WIDTH_32 = 2'd3;

    typedef struct packed {
        logic [2:0] bytes_per_sample;
        logic       big_endian;
        logic       offset_binary_8bit;
        logic       float_samples;
        logic [7:0] channel_count;
    } t_cfg;

    typedef struct packed {
        logic [31:0] seq;
        logic [6:0]  channel;
        logic        last;
    } t_word;

    typedef struct packed {
        logic accept;
        logic complete;
    } t_asm_status;

    // Sample width in bytes minus one, with out-of-range widths clamped.
    function automatic logic [1:0] width_code(input logic [2:0] bps);
        logic [1:0] code;
        if (bps <= 3'd1) begin
            code = WIDTH_8;
        end else if (bps >= 3'd4) begin
            code = WIDTH_32;
        end else begin
            code = 2'(bps - 3'd1);
        end
        return code;
    endfunction

    // Index of the last channel of a frame, with the count clamped to 1..128.
    function automatic logic [6:0] last_channel(input logic [7:0] cc);
        logic [6:0] idx;
        if (cc == 8'd0) begin
            idx = 7'd0;
        end else if (cc > 8'd128) begin
            idx = 7'd127;
        end else begin
            idx = 7'(cc - 8'd1);
        end
        return idx;
    endfunction

    // IEEE single to Q1.31, truncated toward zero and saturated to [-1, 1).
    function automatic logic [31:0] float_to_q31(input logic [31:0] bits);
        logic        neg;
        logic [7:0]  ex;
        logic [22:0] man;
        logic [31:0] mant_ext;
        logic [31:0] mag;
        logic [7:0]  rsh;
        logic [2:0]  lsh;
        logic [31:0] res;
        neg      = bits[31];
        ex       = bits[30:23];
        man      = bits[22:0];
        mant_ext = {8'd0, 1'b1, man};
        lsh      = 3'(ex - 8'd119);
        rsh      = 8'd119 - ex;
        if (ex >= 8'd119) begin
            mag = mant_ext << lsh;
        end else if (rsh >= 8'd32) begin
            mag = 32'd0;
        end else begin
            mag = mant_ext >> rsh[4:0];
        end
        if (ex == 8'hFF && man != 23'd0) begin
            res = 32'd0;
        end else if (ex == 8'd0) begin
            res = 32'd0;
        end else if (ex >= 8'd127) begin
            res = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            res = neg ? (32'd0 - mag) : mag;
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/pcm_sample_unpacker_core.sv =====
// Top level of the PCM sample unpacker: configuration registers and the two stages.
//
// The slave stream takes one raw byte of a WAV or AIFF sample data chunk per transfer.
// The master stream gives one decoded Q1.31 sample per completed sample, with its
// channel index in tuser and tlast set on the last channel of a frame.
// Configuration writes go through a separate index/data channel that is always ready;
// they are meant to happen only while no sample is in flight.
// One byte is taken every cycle while the assembly register is free to load.
// A sample leaves through one register stage after byte assembly and one after
// the conversion logic; the slow path is the float barrel shift and negate.
// When the receiver stalls, the result register holds and the assembly register
// fills behind it; the slave side then stops only once both stages hold a sample.
// Reset clears the byte position, the channel counter and both valid flags, and
// loads the register defaults: 16-bit little-endian integers, two channels.
module pcm_sample_unpacker_core import psu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [7:0] data_byte
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,  // [31:0] sample_value
    output logic [6:0]           m_axis_tuser,  // [6:0] channel_index
    output logic                 m_axis_tlast
);

    t_cfg        r_cfg;
    t_word       word;
    logic        word_valid;
    logic        word_ready;
    t_asm_status status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bytes_per_sample   <= 3'd2;
            r_cfg.big_endian         <= 1'b0;
            r_cfg.offset_binary_8bit <= 1'b1;
            r_cfg.float_samples      <= 1'b0;
            r_cfg.channel_count      <= 8'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BYTES_PER_SAMPLE:   r_cfg.bytes_per_sample   <= i_cfg_data[2:0];
                CFG_BIG_ENDIAN:         r_cfg.big_endian         <= i_cfg_data[0];
                CFG_OFFSET_BINARY_8BIT: r_cfg.offset_binary_8bit <= i_cfg_data[0];
                CFG_FLOAT_SAMPLES:      r_cfg.float_samples      <= i_cfg_data[0];
                CFG_CHANNEL_COUNT:      r_cfg.channel_count      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    psu_assemble u_assemble (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .o_word_valid (word_valid),
        .i_word_ready (word_ready),
        .o_word       (word),
        .o_status     (status)
    );

    psu_convert u_convert (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_word_valid (word_valid),
        .o_word_ready (word_ready),
        .i_word       (word),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_sample     (m_axis_tdata),
        .o_channel    (m_axis_tuser),
        .o_last       (m_axis_tlast)
    );

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !word_valid)
        else $error("pipeline not empty after reset");

    a_complete_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.accept && status.complete |=> word_valid)
        else $error("completed sample not captured");

    a_output_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(word_valid))
        else $error("result appeared without an assembled sample");

endmodule

// ===== hw/rtl/psu_assemble.sv =====
// Byte assembly stage: collects the bytes of one sample and tracks the channel.
module psu_assemble import psu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte,
    output logic        o_word_valid,
    input  logic        i_word_ready,
    output t_word       o_word,
    output t_asm_status o_status
);

    logic [1:0]  r_pos, n_pos;
    logic [23:0] r_partial, n_partial;
    logic [6:0]  r_chan, n_chan;
    logic        r_valid, n_valid;
    t_word       r_word;

    logic [1:0]  wc;
    logic [6:0]  last_idx;
    logic        accept;
    logic        complete;
    logic        last;
    logic [31:0] seq_full;
    logic [31:0] seq;

    assign wc       = width_code(i_cfg.bytes_per_sample);
    assign last_idx = last_channel(i_cfg.channel_count);
    assign o_ready  = !r_valid || i_word_ready;
    assign accept   = i_valid && o_ready;
    assign complete = (r_pos >= wc);
    assign last     = (r_chan >= last_idx);
    assign seq_full = {r_partial, i_byte};

    always_comb begin
        case (wc)
            WIDTH_8:  seq = {24'd0, seq_full[7:0]};
            WIDTH_16: seq = {16'd0, seq_full[15:0]};
            WIDTH_24: seq = {8'd0, seq_full[23:0]};
            default:  seq = seq_full;
        endcase
    end

    always_comb begin
        n_pos     = r_pos;
        n_partial = r_partial;
        n_chan    = r_chan;
        n_valid   = i_word_ready ? 1'b0 : r_valid;
        if (accept) begin
            if (!complete) begin
                n_pos     = r_pos + 2'd1;
                n_partial = {r_partial[15:0], i_byte};
            end else begin
                n_pos     = 2'd0;
                n_partial = 24'd0;
                n_chan    = last ? 7'd0 : r_chan + 7'd1;
                n_valid   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 2'd0;
            r_partial <= 24'd0;
            r_chan    <= 7'd0;
            r_valid   <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_partial <= n_partial;
            r_chan    <= n_chan;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && complete) begin
            r_word.seq     <= seq;
            r_word.channel <= r_chan;
            r_word.last    <= last;
        end
    end

    assign o_word_valid      = r_valid;
    assign o_word            = r_word;
    assign o_status.accept   = accept;
    assign o_status.complete = complete;

endmodule

// ===== hw/rtl/psu_convert.sv =====
// Conversion stage: byte order, scaling or float conversion into the result register.
module psu_convert import psu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_word_valid,
    output logic        o_word_ready,
    input  t_word       i_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_sample,
    output logic [6:0]  o_channel,
    output logic        o_last
);

    logic        r_valid;
    logic [31:0] r_sample;
    logic [6:0]  r_channel;
    logic        r_last;

    logic [1:0]  wc;
    logic [31:0] s;
    logic [31:0] v;
    logic [31:0] q;
    logic [7:0]  b8;
    logic        load;

    assign wc           = width_code(i_cfg.bytes_per_sample);
    assign s            = i_word.seq;
    assign o_word_ready = !r_valid || i_ready;
    assign load         = i_word_valid && o_word_ready;

    always_comb begin
        if (i_cfg.big_endian || wc == WIDTH_8) begin
            v = s;
        end else begin
            case (wc)
                WIDTH_16: v = {16'd0, s[7:0], s[15:8]};
                WIDTH_24: v = {8'd0, s[7:0], s[15:8], s[23:16]};
                default:  v = {s[7:0], s[15:8], s[23:16], s[31:24]};
            endcase
        end
    end

    assign b8 = i_cfg.offset_binary_8bit ? (v[7:0] ^ 8'h80) : v[7:0];

    always_comb begin
        case (wc)
            WIDTH_8:  q = {b8, 24'd0};
            WIDTH_16: q = {v[15:0], 16'd0};
            WIDTH_24: q = {v[23:0], 8'd0};
            default:  q = i_cfg.float_samples ? float_to_q31(v) : v;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sample  <= q;
            r_channel <= i_word.channel;
            r_last    <= i_word.last;
        end
    end

    assign o_valid   = r_valid;
    assign o_sample  = r_sample;
    assign o_channel = r_channel;
    assign o_last    = r_last;

endmodule
